// ----- rtl/regex_subpattern_splitter_unit_assert.svh -----
// assertion macros used by the checker
`ifndef REGEX_SUBPATTERN_SPLITTER_UNIT_ASSERT_SVH
`define REGEX_SUBPATTERN_SPLITTER_UNIT_ASSERT_SVH

// same-cycle implication, held off during reset
`define RSS_AST_IMPLY(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("rss check failed");

// next-cycle implication, held off during reset
`define RSS_AST_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("rss check failed");

// next-cycle implication, also checked across reset
`define RSS_AST_NEXT_ALL(lbl, pre, post) \
  lbl: assert property (@(posedge clk) (pre) |=> (post)) \
    else $error("rss check failed");

`endif

// ----- rtl/rss_pkg.sv -----
package rss_pkg;

  localparam int MAX_DEPTH = 15;
  localparam int DEPTH_W   = $clog2(MAX_DEPTH + 1);

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_CARET  = 8'h5e;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_LPAR   = 8'h28;
  localparam logic [7:0] CH_RPAR   = 8'h29;
  localparam logic [7:0] CH_LBRK   = 8'h5b;
  localparam logic [7:0] CH_RBRK   = 8'h5d;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_STAR   = 8'h2a;
  localparam logic [7:0] CH_PLUS   = 8'h2b;
  localparam logic [7:0] CH_QUEST  = 8'h3f;
  localparam logic [7:0] CH_LBRC   = 8'h7b;
  localparam logic [7:0] CH_RBRC   = 8'h7d;

  typedef enum logic [2:0] {
    MODE_FIRST,
    MODE_START,
    MODE_PREFIX,
    MODE_PAREN,
    MODE_BRACKET,
    MODE_BRACE,
    MODE_GROUP,
    MODE_REP
  } mode_t;

  typedef enum logic [2:0] {
    ST_OK,
    ST_CARET,
    ST_SYNTAX,
    ST_PAREN,
    ST_BRACKET,
    ST_BRACE,
    ST_DOLLAR,
    ST_OVER
  } status_t;

  typedef struct packed {
    logic    seg_start;
    status_t status;
    logic    expr_ok;
  } result_t;

endpackage

// ----- rtl/rss_parse_core.sv -----
module rss_parse_core (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,
  input  logic [7:0]       char_code,
  input  logic             last_char,
  output rss_pkg::result_t res
);
  import rss_pkg::*;

  mode_t               mode_r, mode_nxt;
  logic [DEPTH_W-1:0]  depth_r, depth_nxt;
  status_t             st_r, st_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_FIRST;
      depth_r <= '0;
      st_r    <= ST_OK;
    end else if (step) begin
      if (last_char) begin
        mode_r  <= MODE_FIRST;
        depth_r <= '0;
        st_r    <= ST_OK;
      end else begin
        mode_r  <= mode_nxt;
        depth_r <= depth_nxt;
        st_r    <= st_nxt;
      end
    end
  end

  always_comb begin
    logic       do_start;
    logic       at_zero;
    logic       new_seg;
    logic [7:0] open_ch;
    logic [7:0] close_ch;
    status_t    grp_err;

    mode_nxt  = mode_r;
    depth_nxt = depth_r;
    st_nxt    = st_r;
    do_start  = 1'b0;
    at_zero   = 1'b0;
    new_seg   = 1'b0;
    open_ch   = (mode_r == MODE_PAREN) ? CH_LPAR : CH_LBRK;
    close_ch  = (mode_r == MODE_PAREN) ? CH_RPAR : CH_RBRK;
    grp_err   = (mode_r == MODE_PAREN) ? ST_PAREN : ST_BRACKET;

    if (st_r == ST_OK) begin
      case (mode_r)
        MODE_FIRST, MODE_START: begin
          new_seg  = 1'b1;
          do_start = 1'b1;
          at_zero  = (mode_r == MODE_FIRST);
        end
        MODE_PREFIX: begin
          do_start = 1'b1;
        end
        MODE_PAREN, MODE_BRACKET: begin
          if (char_code == CH_NUL) begin
            st_nxt = grp_err;
          end else if (char_code == open_ch) begin
            if (depth_r >= DEPTH_W'(MAX_DEPTH)) begin
              st_nxt = ST_OVER;
            end else begin
              depth_nxt = depth_r + 1'b1;
            end
          end else if (char_code == close_ch) begin
            depth_nxt = depth_r - 1'b1;
            if (depth_r == DEPTH_W'(1)) begin
              mode_nxt = MODE_GROUP;
            end
          end
        end
        MODE_BRACE: begin
          if (char_code == CH_NUL) begin
            st_nxt = ST_BRACE;
          end else if (char_code == CH_RBRC) begin
            mode_nxt = MODE_REP;
          end
        end
        MODE_GROUP, MODE_REP: begin
          if (mode_r == MODE_GROUP && char_code inside {CH_STAR, CH_PLUS, CH_QUEST}) begin
            mode_nxt = MODE_REP;
          end else if (mode_r == MODE_GROUP && char_code == CH_LBRC) begin
            mode_nxt = MODE_BRACE;
          end else if (char_code == CH_DOLLAR) begin
            if (last_char) begin
              mode_nxt = MODE_REP;
            end else begin
              st_nxt = ST_DOLLAR;
            end
          end else begin
            new_seg  = 1'b1;
            do_start = 1'b1;
          end
        end
        default: begin
          mode_nxt = mode_r;
        end
      endcase
    end

    if (do_start) begin
      case (char_code)
        CH_CARET: begin
          if (at_zero) begin
            mode_nxt = MODE_PREFIX;
          end else begin
            st_nxt = ST_CARET;
          end
        end
        CH_BANG: begin
          mode_nxt = MODE_PREFIX;
        end
        CH_LPAR: begin
          depth_nxt = DEPTH_W'(1);
          mode_nxt  = MODE_PAREN;
        end
        CH_LBRK: begin
          depth_nxt = DEPTH_W'(1);
          mode_nxt  = MODE_BRACKET;
        end
        default: begin
          st_nxt = ST_SYNTAX;
        end
      endcase
    end

    res.seg_start = new_seg && (st_nxt == ST_OK);

    // end of expression: anything still open is a mismatch; a prefix or a missing sub-pattern is a syntax error
    if (last_char && st_nxt == ST_OK) begin
      case (mode_nxt)
        MODE_PAREN:                          st_nxt = ST_PAREN;
        MODE_BRACKET:                        st_nxt = ST_BRACKET;
        MODE_BRACE:                          st_nxt = ST_BRACE;
        MODE_PREFIX, MODE_FIRST, MODE_START: st_nxt = ST_SYNTAX;
        default:                             st_nxt = st_nxt;
      endcase
    end

    res.status  = st_nxt;
    res.expr_ok = last_char && (st_nxt == ST_OK);
  end

endmodule

// ----- rtl/regex_subpattern_splitter_unit.sv -----
// Splits a regex expression, fed one byte per beat with the final byte
// marked by in_last_char, into sub-patterns: one result beat per input
// beat, with out_seg_start on each byte that opens a sub-pattern, the
// sticky error code on out_status and out_expr_ok on the final byte of a
// valid expression. One byte is taken every cycle while out_ready is high;
// a byte goes from the input register to the result register, and the
// parse state for the next expression is cleared by the final byte
// itself, so expressions may follow back to back.
module regex_subpattern_splitter_unit (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_char_code,
  input  logic       in_last_char,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_seg_start,
  output logic [2:0] out_status,
  output logic       out_expr_ok
);
  import rss_pkg::*;

  logic       in_v_r;
  logic [7:0] char_r;
  logic       last_r;
  logic       out_v_r;
  result_t    res_r;
  result_t    res;
  logic       adv;

  assign adv      = in_v_r && (!out_v_r || out_ready);
  assign in_ready = !in_v_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ready) begin
      in_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      char_r <= in_char_code;
      last_r <= in_last_char;
    end
  end

  rss_parse_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (adv),
    .char_code (char_r),
    .last_char (last_r),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= 1'b1;
    end else if (out_ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_r <= res;
    end
  end

  assign out_valid     = out_v_r;
  assign out_seg_start = res_r.seg_start;
  assign out_status    = res_r.status;
  assign out_expr_ok   = res_r.expr_ok;

endmodule

// ----- rtl/rss_checker.sv -----
`include "regex_subpattern_splitter_unit_assert.svh"

module rss_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic [7:0] in_char_code,
  input logic       in_last_char,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_seg_start,
  input logic [2:0] out_status,
  input logic       out_expr_ok
);
  import rss_pkg::*;

  // a valid expression never reports an error code
  `RSS_AST_IMPLY(a_ok_no_err, out_valid && out_expr_ok, out_status == ST_OK)

  // a new sub-pattern is never flagged on a byte that raised a stray error
  `RSS_AST_IMPLY(a_seg_no_err, out_valid && out_seg_start, out_status != ST_CARET && out_status != ST_DOLLAR && out_status != ST_OVER)

  // a stalled result beat holds
  `RSS_AST_NEXT(a_out_hold, out_valid && !out_ready,
                out_valid && $stable(out_status) && $stable(out_seg_start))

  // no result beat straight out of reset
  `RSS_AST_NEXT_ALL(a_rst_quiet, !rst_n, !out_valid)

endmodule

bind regex_subpattern_splitter_unit rss_checker u_rss_checker (.*);
